/* sv/nsecbw_pkg.sv */
// ----------------------------------------------------------------------------
// nsecbw_pkg: shared types and helpers for the NSEC type bitmap window
// Holds the window size, request codes, the control and status bundles that
// join the controller to the datapath, and small bit-counting functions.
// ----------------------------------------------------------------------------
`default_nettype none

package nsecbw_pkg;

  localparam int unsigned WINDOW_BYTES = 32;
  localparam int unsigned PTR_W        = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned CNT_W        = 9;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_TEST  = 2'd2,
    REQ_FETCH = 2'd3
  } req_e;

  typedef struct packed {
    logic capture;
    logic modify;
    logic scan_step;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic scan_last;
    logic out_free;
  } status_t;

  function automatic logic [3:0] popcount8(input logic [7:0] val);
    logic [3:0] sum;
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      sum = sum + {3'b000, val[b]};
    end
    return sum;
  endfunction

  // Position of the k-th set bit (from zero, ascending) within one byte.
  function automatic logic [2:0] select_bit(input logic [7:0] val, input logic [2:0] k);
    logic [3:0] seen;
    logic [2:0] pos;
    logic       got;
    seen = '0;
    pos  = '0;
    got  = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (val[b]) begin
        if (!got && seen == {1'b0, k}) begin
          pos = 3'(b);
          got = 1'b1;
        end
        seen = seen + 4'd1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* sv/nsecbw_ctrl.sv */
// ----------------------------------------------------------------------------
// nsecbw_ctrl: sequencing controller for the type bitmap window
// Steps each word through modify, scan and commit if needed, and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module nsecbw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  nsecbw_pkg::status_t status_i,
  output nsecbw_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = status_i.go_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MODIFY))
    else $error("accepted word did not start the modify step");

endmodule

`default_nettype wire

/* sv/nsecbw_dpath.sv */
// ----------------------------------------------------------------------------
// nsecbw_dpath: bitmap storage, byte scanner and result register
// Holds the window bitmap and its summary, walks one byte per cycle to
// rebuild length and count or to find the n-th set type, and keeps the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsecbw_dpath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  nsecbw_pkg::cmd_t     cmd_i,
  output nsecbw_pkg::status_t  status_o,
  input  wire  [1:0]           req_type_i,
  input  wire  [15:0]          type_code_i,
  input  wire  [7:0]           type_index_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 bit_hit_o,
  output logic                 active_o,
  output logic [7:0]           window_o,
  output logic [5:0]           octet_length_o,
  output logic [8:0]           set_count_o,
  output logic                 fetch_valid_o,
  output logic [15:0]          fetched_type_o
);

  localparam int unsigned WB    = nsecbw_pkg::WINDOW_BYTES;
  localparam int unsigned PTR_W = nsecbw_pkg::PTR_W;
  localparam int unsigned LEN_W = nsecbw_pkg::LEN_W;
  localparam int unsigned CNT_W = nsecbw_pkg::CNT_W;

  // Captured request.
  logic [1:0]        req_q;
  logic [15:0]       code_q;
  logic [7:0]        want_q;

  // Window state.
  logic [7:0]        bitmap_q [WB];
  logic [7:0]        win_q;
  logic              active_q;
  logic [LEN_W-1:0]  len_q;
  logic [CNT_W-1:0]  total_q;

  // Scan state.
  logic [PTR_W-1:0]  ptr_q;
  logic [LEN_W-1:0]  acc_len_q;
  logic [CNT_W-1:0]  acc_cnt_q;
  logic [CNT_W-1:0]  seen_q;
  logic              found_q;
  logic [PTR_W-1:0]  fbyte_q;
  logic [2:0]        fbit_q;
  logic              hit_q;

  // Result register.
  logic              out_valid_q;
  logic              out_hit_q;
  logic              out_active_q;
  logic [7:0]        out_win_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_fvalid_q;
  logic [15:0]       out_ftype_q;

  logic [7:0]        hi;
  logic [4:0]        byte_idx;
  logic [2:0]        bit_pos;
  logic              in_range;
  logic              is_update;
  logic              lock;
  logic [7:0]        eff_win;
  logic              match;
  logic [7:0]        cur_byte;
  logic [7:0]        new_byte;
  logic [7:0]        scan_byte;
  logic [3:0]        scan_pc;
  logic [CNT_W-1:0]  seen_next;
  logic              sel_here;
  logic [2:0]        sel_pos;
  logic              is_fetch;
  logic              fetch_ok;

  assign hi        = code_q[15:8];
  assign byte_idx  = code_q[7:3];
  assign bit_pos   = code_q[2:0];
  assign in_range  = ({1'b0, byte_idx} < 6'(WB));
  assign is_update = (req_q == nsecbw_pkg::REQ_SET) || (req_q == nsecbw_pkg::REQ_CLEAR);
  assign is_fetch  = (req_q == nsecbw_pkg::REQ_FETCH);
  assign lock      = (req_q == nsecbw_pkg::REQ_SET) && !active_q;
  assign eff_win   = lock ? hi : win_q;
  assign match     = is_update && (hi == eff_win) && in_range;
  assign fetch_ok  = is_fetch && ({1'b0, want_q} < total_q);

  // The request's byte feeds the update and the test; the scan byte is the
  // one under the scan pointer.
  assign cur_byte  = in_range ? bitmap_q[byte_idx[PTR_W-1:0]] : 8'h00;
  assign new_byte  = (req_q == nsecbw_pkg::REQ_SET) ? (cur_byte | (8'h01 << bit_pos))
                                                    : (cur_byte & ~(8'h01 << bit_pos));
  assign scan_byte = bitmap_q[ptr_q];
  assign scan_pc   = nsecbw_pkg::popcount8(scan_byte);
  assign seen_next = seen_q + CNT_W'(scan_pc);
  assign sel_here  = is_fetch && !found_q && (seen_next > {1'b0, want_q});
  assign sel_pos   = nsecbw_pkg::select_bit(scan_byte, 3'(want_q - seen_q[7:0]));

  assign status_o.go_scan   = match || fetch_ok;
  assign status_o.scan_last = (ptr_q == PTR_W'(WB - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      code_q <= type_code_i;
      want_q <= type_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WB; i++) begin
        bitmap_q[i] <= 8'h00;
      end
      win_q    <= '0;
      active_q <= 1'b0;
      len_q    <= '0;
      total_q  <= '0;
    end else begin
      if (cmd_i.modify && is_update) begin
        if (lock) begin
          active_q <= 1'b1;
          win_q    <= hi;
        end
        if (match) begin
          bitmap_q[byte_idx[PTR_W-1:0]] <= new_byte;
          active_q <= 1'b1;
        end
      end
      if (cmd_i.commit && is_update) begin
        if (acc_cnt_q == '0) begin
          active_q <= 1'b0;
          len_q    <= '0;
          total_q  <= '0;
        end else begin
          len_q    <= acc_len_q;
          total_q  <= acc_cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.modify) begin
      found_q <= 1'b0;
      hit_q   <= (req_q == nsecbw_pkg::REQ_TEST) && (hi == win_q) && in_range
                 && ({1'b0, byte_idx} < len_q) && cur_byte[bit_pos];
    end else if (cmd_i.scan_step && sel_here) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      ptr_q     <= '0;
      acc_len_q <= '0;
      acc_cnt_q <= '0;
      seen_q    <= '0;
    end else if (cmd_i.scan_step) begin
      ptr_q     <= ptr_q + PTR_W'(1);
      acc_cnt_q <= acc_cnt_q + CNT_W'(scan_pc);
      seen_q    <= seen_next;
      if (scan_byte != 8'h00) begin
        acc_len_q <= LEN_W'(ptr_q) + LEN_W'(1);
      end
      if (sel_here) begin
        fbyte_q <= ptr_q;
        fbit_q  <= sel_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q    <= hit_q;
      out_active_q <= active_q;
      out_win_q    <= win_q;
      out_len_q    <= len_q;
      out_cnt_q    <= total_q;
      out_fvalid_q <= is_fetch && found_q;
      out_ftype_q  <= (is_fetch && found_q) ? {win_q, 5'(fbyte_q), fbit_q} : 16'h0000;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bit_hit_o      = out_hit_q;
  assign active_o       = out_active_q;
  assign window_o       = out_win_q;
  assign octet_length_o = out_len_q;
  assign set_count_o    = out_cnt_q;
  assign fetch_valid_o  = out_fvalid_q;
  assign fetched_type_o = out_ftype_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q == '0) == (len_q == '0))
    else $error("octet length and set count disagree on an empty window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> active_q)
    else $error("window holds set types but is marked inactive");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q <= LEN_W'(WB)) && (total_q <= CNT_W'(8 * WB)))
    else $error("summary exceeds the window size");

endmodule

`default_nettype wire

/* sv/nsec_type_bitmap_window.sv */
// ----------------------------------------------------------------------------
// nsec_type_bitmap_window: one DNSSEC NSEC type bitmap window
// Set, clear, test and ordinal fetch on a 256-type bitmap window.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on in_valid_i / in_stall_o; result words leave on
//   out_valid_o / out_stall_i. A word moves when valid is high and stall low.
//   Each request word yields exactly one result word with the window summary
//   as it stands after the request.
//   A set or clear that hits the window, and a fetch whose ordinal exists,
//   walk the bitmap one byte per cycle before the result is loaded; a test
//   and every other request skip the scan and go to the result load.
//   One request is in work at a time; in_stall_o is high from acceptance
//   until the result is loaded into the output register, and the next word
//   can be taken in the cycle after that load.
//   A result waiting in the output register does not block the next request;
//   if the receiver stalls, the following result waits in the controller
//   until the output register is free.
//   Reset clears the bitmap, window number, length and count, and leaves the
//   block idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module nsec_type_bitmap_window (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  req_type_i,
  input  wire  [15:0] type_code_i,
  input  wire  [7:0]  type_index_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        bit_hit_o,
  output logic        active_o,
  output logic [7:0]  window_o,
  output logic [5:0]  octet_length_o,
  output logic [8:0]  set_count_o,
  output logic        fetch_valid_o,
  output logic [15:0] fetched_type_o
);

  nsecbw_pkg::cmd_t    cmd;
  nsecbw_pkg::status_t status;

  nsecbw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nsecbw_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (req_type_i),
    .type_code_i    (type_code_i),
    .type_index_i   (type_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bit_hit_o      (bit_hit_o),
    .active_o       (active_o),
    .window_o       (window_o),
    .octet_length_o (octet_length_o),
    .set_count_o    (set_count_o),
    .fetch_valid_o  (fetch_valid_o),
    .fetched_type_o (fetched_type_o)
  );

endmodule

`default_nettype wire

/* dv/nsec_window_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nsec_window_checker: scoreboard for the NSEC type bitmap window
// Watches both channels, keeps its own copy of the bitmap window, predicts
// the summary word for every accepted request word and compares it field by
// field with the next result word that leaves the block.
// ----------------------------------------------------------------------------
module nsec_window_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] type_code_i,
  input  logic [7:0]  type_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        bit_hit_i,
  input  logic        active_i,
  input  logic [7:0]  window_i,
  input  logic [5:0]  octet_length_i,
  input  logic [8:0]  set_count_i,
  input  logic        fetch_valid_i,
  input  logic [15:0] fetched_type_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          peak_count_o
);

  typedef struct packed {
    logic                         bit_hit;
    logic                         active;
    logic [7:0]                   window;
    logic [nsecbw_pkg::LEN_W-1:0] octet_length;
    logic [nsecbw_pkg::CNT_W-1:0] set_count;
    logic                         fetch_valid;
    logic [15:0]                  fetched_type;
  } summary_t;

  logic [7:0]                   bitmap [nsecbw_pkg::WINDOW_BYTES];
  logic [7:0]                   win_num;
  logic                         win_act;
  logic [nsecbw_pkg::LEN_W-1:0] win_len;
  logic [nsecbw_pkg::CNT_W-1:0] win_cnt;
  summary_t                     summary_q [$];
  int                           errors  = 0;
  int                           checked = 0;
  int                           peak    = 0;
  int                           pending = 0;

  assign fail_count_o = errors;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign peak_count_o = peak;

  task automatic predict_summary(input nsecbw_pkg::req_e req, input logic [15:0] code,
                                 input logic [7:0] want, output summary_t s);
    logic [7:0]  hi;
    int unsigned idx, pos, len, cnt, seen, i, b;
    hi   = code[15:8];
    idx  = {27'd0, code[7:3]};
    pos  = {29'd0, code[2:0]};
    seen = 0;
    s    = '0;
    case (req)
      nsecbw_pkg::REQ_SET, nsecbw_pkg::REQ_CLEAR: begin
        // The first set while inactive locks the window, even when its byte
        // falls outside the stored bitmap.
        if (req == nsecbw_pkg::REQ_SET && !win_act) begin
          win_act = 1'b1;
          win_num = hi;
        end
        if (hi == win_num && idx < nsecbw_pkg::WINDOW_BYTES) begin
          bitmap[idx][pos] = (req == nsecbw_pkg::REQ_SET);
          len = 0;
          cnt = 0;
          for (i = 0; i < nsecbw_pkg::WINDOW_BYTES; i++) begin
            if (bitmap[i] != 8'h00) len = i + 1;
            for (b = 0; b < 8; b++) cnt += {31'd0, bitmap[i][b]};
          end
          win_act = (cnt != 0);
          win_len = nsecbw_pkg::LEN_W'(len);
          win_cnt = nsecbw_pkg::CNT_W'(cnt);
        end
      end
      nsecbw_pkg::REQ_TEST: begin
        if (hi == win_num && idx < win_len && idx < nsecbw_pkg::WINDOW_BYTES) begin
          s.bit_hit = bitmap[idx][pos];
        end
      end
      default: begin
        if (want < win_cnt) begin
          for (i = 0; i < win_len && i < nsecbw_pkg::WINDOW_BYTES; i++) begin
            for (b = 0; b < 8; b++) begin
              if (bitmap[i][b]) begin
                if (seen == want && !s.fetch_valid) begin
                  s.fetch_valid  = 1'b1;
                  s.fetched_type = {win_num, 8'(i * 8 + b)};
                end
                seen++;
              end
            end
          end
        end
      end
    endcase
    s.active       = win_act;
    s.window       = win_num;
    s.octet_length = win_len;
    s.set_count    = win_cnt;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    summary_t want_s;
    summary_t got_s;
    if (!rst_ni) begin
      foreach (bitmap[i]) bitmap[i] = 8'h00;
      win_num = '0;
      win_act = 1'b0;
      win_len = '0;
      win_cnt = '0;
      summary_q.delete();
    end else begin
      // A result word always belongs to an earlier request, so it is
      // matched before the request accepted at the same edge is queued.
      if (out_valid_i && !out_stall_i) begin
        got_s = {bit_hit_i, active_i, window_i, octet_length_i, set_count_i,
                 fetch_valid_i, fetched_type_i};
        if (summary_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, got_s);
        end else begin
          want_s = summary_q.pop_front();
          check_field("bit_hit", 16'(want_s.bit_hit), 16'(got_s.bit_hit));
          check_field("active", 16'(want_s.active), 16'(got_s.active));
          check_field("window", 16'(want_s.window), 16'(got_s.window));
          check_field("octet_length", 16'(want_s.octet_length), 16'(got_s.octet_length));
          check_field("set_count", 16'(want_s.set_count), 16'(got_s.set_count));
          check_field("fetch_valid", 16'(want_s.fetch_valid), 16'(got_s.fetch_valid));
          check_field("fetched_type", want_s.fetched_type, got_s.fetched_type);
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_summary(nsecbw_pkg::req_e'(req_type_i), type_code_i, type_index_i, want_s);
        summary_q.push_back(want_s);
        if (int'(win_cnt) > peak) peak = int'(win_cnt);
      end
    end
    pending = summary_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the NSEC type bitmap window
// Drives directed requests, random episodes of sets, clears, tests and
// fetches, and a full-window sweep, under three idle and stall mixes. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  nsecbw_pkg::req_e  req_type   = nsecbw_pkg::REQ_SET;
  logic [15:0]       type_code  = '0;
  logic [7:0]        type_index = '0;
  logic              out_stall  = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              bit_hit;
  logic              active;
  logic [7:0]        window;
  logic [5:0]        octet_length;
  logic [8:0]        set_count;
  logic              fetch_valid;
  logic [15:0]       fetched_type;

  int          fail_count;
  int          pending;
  int          checked;
  int          peak_count;
  int          send_idle_pct  = 11;
  int          recv_stall_pct = 50;
  int          words_sent     = 0;
  logic [7:0]  win_hint       = 8'h00;
  // Every code set since the window was last drained; clearing them all
  // empties the window again.
  bit          set_codes [logic [15:0]];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  nsec_type_bitmap_window i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .type_code_i    (type_code),
    .type_index_i   (type_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .bit_hit_o      (bit_hit),
    .active_o       (active),
    .window_o       (window),
    .octet_length_o (octet_length),
    .set_count_o    (set_count),
    .fetch_valid_o  (fetch_valid),
    .fetched_type_o (fetched_type)
  );

  nsec_window_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .type_code_i    (type_code),
    .type_index_i   (type_index),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .bit_hit_i      (bit_hit),
    .active_i       (active),
    .window_i       (window),
    .octet_length_i (octet_length),
    .set_count_i    (set_count),
    .fetch_valid_i  (fetch_valid),
    .fetched_type_i (fetched_type),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .peak_count_o   (peak_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Stall is sampled on the falling edge, where it is stable until the
  // rising edge that decides whether the word moves.
  task automatic send_word(input nsecbw_pkg::req_e req, input logic [15:0] code,
                           input logic [7:0] idx);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    type_code  <= code;
    type_index <= idx;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    words_sent++;
    if (req == nsecbw_pkg::REQ_SET) set_codes[code] = 1'b1;
  endtask

  task automatic send_probe(input logic [7:0] hi, input int unsigned idx_max);
    if ($urandom_range(1) == 0) begin
      send_word(nsecbw_pkg::REQ_TEST, {hi, 8'($urandom)}, 8'($urandom));
    end else begin
      send_word(nsecbw_pkg::REQ_FETCH, 16'($urandom), 8'($urandom_range(0, idx_max)));
    end
  endtask

  task automatic drain_window();
    foreach (set_codes[c]) begin
      send_word(nsecbw_pkg::REQ_CLEAR, c, 8'($urandom));
      if ($urandom_range(7) == 0) send_probe(c[15:8], 64);
    end
    set_codes.delete();
  endtask

  task automatic sweep_fill();
    logic [7:0] start;
    start = 8'($urandom);
    for (int k = 0; k < 256; k++) begin
      send_word(nsecbw_pkg::REQ_SET, {win_hint, 8'(start + k)}, 8'($urandom));
      if ($urandom_range(7) == 0) send_probe(win_hint, 255);
    end
    send_word(nsecbw_pkg::REQ_FETCH, 16'($urandom), 8'd255);
    send_word(nsecbw_pkg::REQ_FETCH, 16'($urandom), 8'd0);
    send_word(nsecbw_pkg::REQ_TEST, {win_hint, 8'hFF}, 8'($urandom));
  endtask

  task automatic directed_words();
    send_word(nsecbw_pkg::REQ_TEST, 16'h0000, 8'h00);
    send_word(nsecbw_pkg::REQ_FETCH, 16'h0000, 8'h00);
    // Clear while nothing is locked matches the window number from reset.
    send_word(nsecbw_pkg::REQ_CLEAR, 16'h0005, 8'h00);
    send_word(nsecbw_pkg::REQ_SET, 16'hFFFF, 8'hFF);
    send_word(nsecbw_pkg::REQ_SET, 16'h0100, 8'h00);
    send_word(nsecbw_pkg::REQ_SET, 16'hFF00, 8'h00);
    send_word(nsecbw_pkg::REQ_TEST, 16'hFF00, 8'h00);
    send_word(nsecbw_pkg::REQ_TEST, 16'h00FF, 8'h00);
    send_word(nsecbw_pkg::REQ_FETCH, 16'h0000, 8'h00);
    send_word(nsecbw_pkg::REQ_FETCH, 16'hFFFF, 8'h01);
    send_word(nsecbw_pkg::REQ_FETCH, 16'h0000, 8'h02);
    send_word(nsecbw_pkg::REQ_FETCH, 16'hFFFF, 8'hFF);
    send_word(nsecbw_pkg::REQ_CLEAR, 16'h01FF, 8'h00);
    send_word(nsecbw_pkg::REQ_CLEAR, 16'hFFFF, 8'h00);
    // The top byte is now beyond the octet length.
    send_word(nsecbw_pkg::REQ_TEST, 16'hFFFF, 8'h00);
    send_word(nsecbw_pkg::REQ_CLEAR, 16'hFF00, 8'h00);
    send_word(nsecbw_pkg::REQ_TEST, 16'hFF00, 8'h00);
    send_word(nsecbw_pkg::REQ_CLEAR, 16'hFF00, 8'h00);
    send_word(nsecbw_pkg::REQ_SET, 16'h1234, 8'h00);
    send_word(nsecbw_pkg::REQ_SET, 16'h12AA, 8'h00);
    send_word(nsecbw_pkg::REQ_SET, 16'h1200, 8'h00);
    send_word(nsecbw_pkg::REQ_FETCH, 16'h0000, 8'h01);
    send_word(nsecbw_pkg::REQ_FETCH, 16'h0000, 8'h02);
    drain_window();
  endtask

  // Episodes of a random length, each with its own mix of sets and clears
  // and a band of low bytes; a few noise words aim at other windows.
  task automatic random_traffic(input int n);
    int unsigned      span, base, set_pct, pick, idx_max;
    logic [7:0]       hi;
    logic [7:0]       low;
    nsecbw_pkg::req_e req;
    int               left;
    left = n;
    while (left > 0) begin
      if ($urandom_range(5) == 0) begin
        drain_window();
        if ($urandom_range(2) == 0) win_hint = 8'($urandom);
      end
      case ($urandom_range(3))
        0:       span = 255;
        1:       span = $urandom_range(0, 7);
        2:       span = $urandom_range(8, 40);
        default: span = $urandom_range(0, 255);
      endcase
      base    = $urandom_range(0, 255 - span);
      set_pct = $urandom_range(20, 90);
      idx_max = (span < 64) ? span + 1 : 80;
      repeat ($urandom_range(10, 60)) begin
        if (left > 0) begin
          pick = $urandom_range(99);
          hi   = ($urandom_range(9) == 0) ? 8'($urandom) : win_hint;
          low  = 8'(base + $urandom_range(0, span));
          if (pick < 60) begin
            req = ($urandom_range(99) < set_pct) ? nsecbw_pkg::REQ_SET
                                                 : nsecbw_pkg::REQ_CLEAR;
          end else if (pick < 80) begin
            req = nsecbw_pkg::REQ_TEST;
          end else begin
            req = nsecbw_pkg::REQ_FETCH;
          end
          if (req == nsecbw_pkg::REQ_FETCH && $urandom_range(3) != 0) begin
            send_word(req, {hi, low}, 8'($urandom_range(0, idx_max)));
          end else begin
            send_word(req, {hi, low}, 8'($urandom));
          end
          left--;
        end
      end
    end
  endtask

  initial begin
    int waited;
    waited = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    random_traffic(480);

    send_idle_pct  = 50;
    recv_stall_pct = 11;
    drain_window();
    sweep_fill();
    drain_window();
    random_traffic(80);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(460);
    in_valid <= 1'b0;

    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    @(negedge clk);
    if (pending != 0) $display("%0d result words never arrived", pending);

    $display("Sent %0d request words: directed cases, random episodes with drains,",
             words_sent);
    $display("and a full-window sweep; %0d result words checked, peak type count %0d.",
             checked, peak_count);
    if (fail_count == 0 && pending == 0) begin
      $display("nsec_type_bitmap_window test passed");
    end else begin
      $display("nsec_type_bitmap_window test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("nsec_type_bitmap_window test failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/nsecbw_pkg.sv
sv/nsecbw_ctrl.sv
sv/nsecbw_dpath.sv
sv/nsec_type_bitmap_window.sv
dv/nsec_window_checker.sv
dv/tb_top.sv
